// ----- hdl/dia_pkg.sv -----
package dia_pkg;

   localparam int MAX_SLOTS  = 1024;
   localparam int SLOT_W     = $clog2(MAX_SLOTS);
   localparam int COUNT_W    = $clog2(MAX_SLOTS + 1);

   localparam int INDEX_W    = 32;
   localparam int CAP_W      = 11;
   localparam int OUT_CNT_W  = 11;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 32;

   localparam int REQ_TDATA_W = 32;
   localparam int RSP_FIELD_W = INDEX_W + 1 + OUT_CNT_W + OUT_CNT_W;
   localparam int RSP_TDATA_W = ((RSP_FIELD_W + 7) / 8) * 8;

   localparam logic [INDEX_W-1:0] INVALID_INDEX = '1;
   localparam logic [CAP_W-1:0]   CAP_RESET     = CAP_W'(1024);

   localparam logic CMD_ALLOCATE = 1'b0;
   localparam logic CMD_RELEASE  = 1'b1;

   localparam logic [CSR_IDX_W-1:0] REG_SEGMENT_BASE     = 1'b0;
   localparam logic [CSR_IDX_W-1:0] REG_SEGMENT_CAPACITY = 1'b1;

endpackage

// ----- hdl/dia_ram.sv -----
module dia_ram #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 2
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hdl/descriptor_index_allocator.sv -----
// Slot index allocator for one segment of a global index space.
// Request channel (req_): tuser carries the command (allocate or release),
// tdata the global index to release. Response channel (rsp_): one transfer
// per request with the granted index, a success flag and the allocated and
// available slot counts after the request.
// Configuration (csr_): write segment base and capacity while idle; a write
// takes effect at the next clock edge.
// Sequencing: a request is taken in the idle state and its response is
// registered on completion in the execute state, after the registered reads
// of the free-stack and in-use bitmap RAMs, which are read on acceptance and
// written back on completion.
// One request is in flight at a time; a finished response may wait in the
// output register while the next request is taken. If the receiver stalls,
// the in-flight request holds until the output register frees up.
// Reset: counters, stack depth and bump cursor clear at once. The bitmap is
// not swept: entries at or beyond the bump cursor read as free, so requests
// are taken from the first cycle after reset.
module descriptor_index_allocator
   import dia_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   // request
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_TDATA_W-1:0] req_tdata,   // [31:0] heap_index
   input  logic                   req_tuser,   // [0] command
   // response
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // [31:0] granted_index, [32] ok, [43:33] allocated_count,
   // [54:44] available_count, [55] zero
   output logic [RSP_TDATA_W-1:0] rsp_tdata,
   // configuration
   input  logic                   csr_we,
   input  logic [CSR_IDX_W-1:0]   csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_EXEC = 1'b1;

   logic               state_ff, state_in;
   logic [INDEX_W-1:0] base_ff;
   logic [CAP_W-1:0]   cap_ff;
   logic [COUNT_W-1:0] depth_ff, depth_in;
   logic [COUNT_W-1:0] cursor_ff, cursor_in;
   logic [COUNT_W-1:0] used_ff, used_in;

   logic               cmd_ff, cmd_in;
   logic [SLOT_W-1:0]  slot_ff, slot_in;
   logic               rel_ok_ff, rel_ok_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic [INDEX_W-1:0]   rsp_granted_ff, rsp_granted_in;
   logic                 rsp_ok_ff, rsp_ok_in;
   logic [OUT_CNT_W-1:0] rsp_alloc_ff, rsp_alloc_in;
   logic [OUT_CNT_W-1:0] rsp_avail_ff, rsp_avail_in;

   logic [COUNT_W-1:0] cap_eff;
   logic [INDEX_W-1:0] diff;
   logic [COUNT_W-1:0] pop_ptr;
   logic               accept;
   logic               commit;
   logic [COUNT_W-1:0] avail;

   logic               stk_we;
   logic [SLOT_W-1:0]  stk_waddr;
   logic [SLOT_W-1:0]  stk_wdata;
   logic [SLOT_W-1:0]  stk_rdata;
   logic               bit_we;
   logic [SLOT_W-1:0]  bit_waddr;
   logic               bit_wdata;
   logic               bit_rdata;

   assign cap_eff = (32'(cap_ff) > 32'(MAX_SLOTS)) ? COUNT_W'(MAX_SLOTS) : COUNT_W'(cap_ff);
   assign diff    = req_tdata[INDEX_W-1:0] - base_ff;
   assign pop_ptr = depth_ff - COUNT_W'(1);

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign commit     = (state_ff == ST_EXEC) && (!rsp_valid_ff || rsp_tready);

   dia_ram #(.WIDTH(SLOT_W), .DEPTH(MAX_SLOTS)) u_stack (
      .clock   (clock),
      .wr_en   (stk_we),
      .wr_addr (stk_waddr),
      .wr_data (stk_wdata),
      .rd_en   (accept),
      .rd_addr (pop_ptr[SLOT_W-1:0]),
      .rd_data (stk_rdata)
   );

   dia_ram #(.WIDTH(1), .DEPTH(MAX_SLOTS)) u_in_use (
      .clock   (clock),
      .wr_en   (bit_we),
      .wr_addr (bit_waddr),
      .wr_data (bit_wdata),
      .rd_en   (accept),
      .rd_addr (diff[SLOT_W-1:0]),
      .rd_data (bit_rdata)
   );

   always_comb begin
      state_in       = state_ff;
      cmd_in         = cmd_ff;
      slot_in        = slot_ff;
      rel_ok_in      = rel_ok_ff;
      depth_in       = depth_ff;
      cursor_in      = cursor_ff;
      used_in        = used_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_granted_in = rsp_granted_ff;
      rsp_ok_in      = rsp_ok_ff;
      rsp_alloc_in   = rsp_alloc_ff;
      rsp_avail_in   = rsp_avail_ff;
      stk_we         = 1'b0;
      stk_waddr      = depth_ff[SLOT_W-1:0];
      stk_wdata      = slot_ff;
      bit_we         = 1'b0;
      bit_waddr      = slot_ff;
      bit_wdata      = 1'b0;
      avail          = '0;

      if (accept) begin
         state_in  = ST_EXEC;
         cmd_in    = req_tuser;
         slot_in   = diff[SLOT_W-1:0];
         rel_ok_in = (req_tdata[INDEX_W-1:0] != INVALID_INDEX)
                     && (req_tdata[INDEX_W-1:0] >= base_ff)
                     && (diff < 32'(cap_eff));
      end

      if (commit) begin
         state_in       = ST_IDLE;
         rsp_granted_in = INVALID_INDEX;
         rsp_ok_in      = 1'b0;
         if (cmd_ff == CMD_ALLOCATE) begin
            if (depth_ff != '0) begin
               // pop the most recently released slot
               depth_in       = pop_ptr;
               bit_we         = 1'b1;
               bit_waddr      = stk_rdata;
               bit_wdata      = 1'b1;
               used_in        = used_ff + COUNT_W'(1);
               rsp_granted_in = base_ff + INDEX_W'(stk_rdata);
               rsp_ok_in      = 1'b1;
            end else if (cursor_ff < cap_eff) begin
               cursor_in      = cursor_ff + COUNT_W'(1);
               bit_we         = 1'b1;
               bit_waddr      = cursor_ff[SLOT_W-1:0];
               bit_wdata      = 1'b1;
               used_in        = used_ff + COUNT_W'(1);
               rsp_granted_in = base_ff + INDEX_W'(cursor_ff[SLOT_W-1:0]);
               rsp_ok_in      = 1'b1;
            end
         end else begin
            // bitmap entries at or past the cursor hold no live allocation: treat as free
            if (rel_ok_ff && bit_rdata && (COUNT_W'(slot_ff) < cursor_ff)) begin
               bit_we = 1'b1;
               if (depth_ff < COUNT_W'(MAX_SLOTS)) begin
                  stk_we   = 1'b1;
                  depth_in = depth_ff + COUNT_W'(1);
               end
               if (used_ff != '0) begin
                  used_in = used_ff - COUNT_W'(1);
               end
               rsp_ok_in = 1'b1;
            end
         end
         avail        = (cap_eff >= used_in) ? (cap_eff - used_in) : '0;
         rsp_valid_in = 1'b1;
         rsp_alloc_in = OUT_CNT_W'(used_in);
         rsp_avail_in = OUT_CNT_W'(avail);
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         depth_ff     <= '0;
         cursor_ff    <= '0;
         used_ff      <= '0;
         base_ff      <= '0;
         cap_ff       <= CAP_RESET;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         depth_ff     <= depth_in;
         cursor_ff    <= cursor_in;
         used_ff      <= used_in;
         if (csr_we && (csr_index == REG_SEGMENT_BASE)) begin
            base_ff <= csr_wdata[INDEX_W-1:0];
         end
         if (csr_we && (csr_index == REG_SEGMENT_CAPACITY)) begin
            cap_ff <= csr_wdata[CAP_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff         <= cmd_in;
      slot_ff        <= slot_in;
      rel_ok_ff      <= rel_ok_in;
      rsp_granted_ff <= rsp_granted_in;
      rsp_ok_ff      <= rsp_ok_in;
      rsp_alloc_ff   <= rsp_alloc_in;
      rsp_avail_ff   <= rsp_avail_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_TDATA_W'({rsp_avail_ff, rsp_alloc_ff, rsp_ok_ff, rsp_granted_ff});

`ifndef SYNTHESIS
   // every slot the cursor has passed is either held or on the free stack
   a_slot_conservation: assert property (@(posedge clock) disable iff (reset)
      (depth_ff + used_ff) == cursor_ff)
      else $error("slot count mismatch between stack, holders and cursor");

   a_cursor_bound: assert property (@(posedge clock) disable iff (reset)
      cursor_ff <= COUNT_W'(MAX_SLOTS))
      else $error("bump cursor beyond segment depth");

   a_release_push: assert property (@(posedge clock) disable iff (reset)
      (commit && (cmd_ff == CMD_RELEASE) && rsp_ok_in)
      |=> (depth_ff == $past(depth_ff) + COUNT_W'(1)))
      else $error("successful release did not push the slot");

   a_rsp_from_exec: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_EXEC))
      else $error("response raised without a request in flight");
`endif

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps

module testbench;
   import dia_pkg::*;

   localparam int CLK_PERIOD   = 12;
   localparam int LIMIT_CYCLES = 200000;
   localparam int NUM_PHASES   = 6;

   typedef struct packed {
      logic [INDEX_W-1:0]   granted;
      logic                 ok;
      logic [OUT_CNT_W-1:0] allocated;
      logic [OUT_CNT_W-1:0] available;
   } alloc_result_type;

   typedef enum logic [1:0] {STEP_SETUP, STEP_CHECKED, STEP_KNOWN} step_kind_type;

   typedef struct packed {
      step_kind_type      kind;
      logic               cmd;
      logic [INDEX_W-1:0] index;     // heap index, or segment base for a setup step
      logic [CAP_W-1:0]   capacity;
      alloc_result_type   want;
   } directed_step_type;

   localparam alloc_result_type NO_RESULT = '0;
   localparam int NUM_DIRECTED = 27;

   localparam directed_step_type DIRECTED [NUM_DIRECTED] = '{
      // fresh segment: base 0, full capacity
      '{STEP_KNOWN, CMD_RELEASE, 32'h0, 11'd0, '{INVALID_INDEX, 1'b0, 11'd0, 11'd1024}},
      '{STEP_KNOWN, CMD_RELEASE, INVALID_INDEX, 11'd0,
        '{INVALID_INDEX, 1'b0, 11'd0, 11'd1024}},
      '{STEP_KNOWN, CMD_ALLOCATE, 32'h0, 11'd0, '{32'h0, 1'b1, 11'd1, 11'd1023}},
      '{STEP_KNOWN, CMD_ALLOCATE, 32'hFFFF_FFFF, 11'd0, '{32'h1, 1'b1, 11'd2, 11'd1022}},
      '{STEP_KNOWN, CMD_RELEASE, 32'h1, 11'd0, '{INVALID_INDEX, 1'b1, 11'd1, 11'd1023}},
      // double free
      '{STEP_KNOWN, CMD_RELEASE, 32'h1, 11'd0, '{INVALID_INDEX, 1'b0, 11'd1, 11'd1023}},
      '{STEP_KNOWN, CMD_ALLOCATE, 32'h0, 11'd0, '{32'h1, 1'b1, 11'd2, 11'd1022}},
      // base near the top while slots are held; slot 2 grants all ones
      '{STEP_SETUP, CMD_ALLOCATE, 32'hFFFF_FFFD, 11'd3, NO_RESULT},
      '{STEP_KNOWN, CMD_ALLOCATE, 32'h0, 11'd0, '{INVALID_INDEX, 1'b1, 11'd3, 11'd0}},
      '{STEP_KNOWN, CMD_ALLOCATE, 32'h0, 11'd0, '{INVALID_INDEX, 1'b0, 11'd3, 11'd0}},
      '{STEP_KNOWN, CMD_RELEASE, INVALID_INDEX, 11'd0,
        '{INVALID_INDEX, 1'b0, 11'd3, 11'd0}},
      '{STEP_KNOWN, CMD_RELEASE, 32'hFFFF_FFFD, 11'd0,
        '{INVALID_INDEX, 1'b1, 11'd2, 11'd1}},
      '{STEP_KNOWN, CMD_RELEASE, 32'hFFFF_FFFE, 11'd0,
        '{INVALID_INDEX, 1'b1, 11'd1, 11'd2}},
      // below base: no wrap on the range test
      '{STEP_KNOWN, CMD_RELEASE, 32'h0, 11'd0, '{INVALID_INDEX, 1'b0, 11'd1, 11'd2}},
      // shrink under the stacked slots; they still pop
      '{STEP_SETUP, CMD_ALLOCATE, 32'hFFFF_FFFD, 11'd1, NO_RESULT},
      '{STEP_KNOWN, CMD_ALLOCATE, 32'h0, 11'd0, '{32'hFFFF_FFFE, 1'b1, 11'd2, 11'd0}},
      '{STEP_KNOWN, CMD_ALLOCATE, 32'h0, 11'd0, '{32'hFFFF_FFFD, 1'b1, 11'd3, 11'd0}},
      '{STEP_KNOWN, CMD_ALLOCATE, 32'h0, 11'd0, '{INVALID_INDEX, 1'b0, 11'd3, 11'd0}},
      // empty segment
      '{STEP_SETUP, CMD_ALLOCATE, 32'h0, 11'd0, NO_RESULT},
      '{STEP_CHECKED, CMD_ALLOCATE, 32'h0, 11'd0, NO_RESULT},
      '{STEP_CHECKED, CMD_RELEASE, 32'h0, 11'd0, NO_RESULT},
      // capacity above the built depth clamps
      '{STEP_SETUP, CMD_ALLOCATE, 32'h8000_0000, 11'd2047, NO_RESULT},
      '{STEP_KNOWN, CMD_ALLOCATE, 32'h0, 11'd0, '{32'h8000_0003, 1'b1, 11'd4, 11'd1020}},
      '{STEP_KNOWN, CMD_RELEASE, 32'h8000_0002, 11'd0,
        '{INVALID_INDEX, 1'b1, 11'd3, 11'd1021}},
      '{STEP_CHECKED, CMD_RELEASE, 32'h8000_0400, 11'd0, NO_RESULT},
      '{STEP_CHECKED, CMD_RELEASE, 32'h7FFF_FFFF, 11'd0, NO_RESULT},
      '{STEP_CHECKED, CMD_ALLOCATE, 32'h0, 11'd0, NO_RESULT}
   };

   logic                   clock;
   logic                   reset      = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata  = '0;
   logic                   req_tuser  = CMD_ALLOCATE;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b1;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic                   csr_we     = 1'b0;
   logic [CSR_IDX_W-1:0]   csr_index  = REG_SEGMENT_BASE;
   logic [CSR_DATA_W-1:0]  csr_wdata  = '0;

   // allocator state as seen by the testbench
   logic [INDEX_W-1:0] seg_base     = '0;
   logic [CAP_W-1:0]   seg_capacity = CAP_RESET;
   logic [SLOT_W-1:0]  free_slots [MAX_SLOTS];
   logic [COUNT_W-1:0] free_depth   = '0;
   logic [COUNT_W-1:0] bump_next    = '0;
   bit                 slot_in_use [MAX_SLOTS];
   logic [COUNT_W-1:0] slots_used   = '0;

   int unsigned      held_slots [$];
   alloc_result_type expected_grants [$];
   int               failures   = 0;
   int               burst_left = 0;

   descriptor_index_allocator i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #(CLK_PERIOD / 2) clock = ~clock;
   end

   function automatic alloc_result_type predict_grant(logic cmd, logic [INDEX_W-1:0] index);
      alloc_result_type   r;
      logic [COUNT_W-1:0] usable;
      logic [SLOT_W-1:0]  slot;
      logic [INDEX_W-1:0] offset;
      int                 k;
      usable    = (seg_capacity > COUNT_W'(MAX_SLOTS)) ? COUNT_W'(MAX_SLOTS) : seg_capacity;
      r.granted = INVALID_INDEX;
      r.ok      = 1'b0;
      slot      = '0;
      if (cmd == CMD_ALLOCATE) begin
         if (free_depth != 0) begin
            free_depth = free_depth - 1'b1;
            slot       = free_slots[free_depth];
            r.ok       = 1'b1;
         end else if (bump_next < usable) begin
            slot      = bump_next[SLOT_W-1:0];
            bump_next = bump_next + 1'b1;
            r.ok      = 1'b1;
         end
         if (r.ok) begin
            slot_in_use[slot] = 1'b1;
            slots_used        = slots_used + 1'b1;
            r.granted         = seg_base + INDEX_W'(slot);
            held_slots.push_back(slot);
         end
      end else if (index != INVALID_INDEX && index >= seg_base) begin
         offset = index - seg_base;
         if (offset < INDEX_W'(usable) && slot_in_use[offset[SLOT_W-1:0]]) begin
            slot              = offset[SLOT_W-1:0];
            slot_in_use[slot] = 1'b0;
            if (free_depth < COUNT_W'(MAX_SLOTS)) begin
               free_slots[free_depth] = slot;
               free_depth             = free_depth + 1'b1;
            end
            if (slots_used != 0)
               slots_used = slots_used - 1'b1;
            r.ok = 1'b1;
            for (k = 0; k < held_slots.size(); k++)
               if (held_slots[k] == slot) begin
                  held_slots.delete(k);
                  break;
               end
         end
      end
      r.allocated = slots_used;
      r.available = (usable >= slots_used) ? usable - slots_used : '0;
      return r;
   endfunction

   function automatic void check_field(string name, logic [INDEX_W-1:0] want,
                                       logic [INDEX_W-1:0] got);
      if (got !== want) begin
         $error("%s: expected %0h, got %0h", name, want, got);
         failures++;
      end
   endfunction

   // offer one request and hold it until the transfer
   task automatic issue(logic cmd, logic [INDEX_W-1:0] index, bit known,
                        alloc_result_type want);
      alloc_result_type r;
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= index;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      r = predict_grant(cmd, index);
      expected_grants.push_back(known ? want : r);
   endtask

   task automatic pace();
      int gap;
      if (burst_left != 0)
         burst_left--;
      else begin
         gap        = $urandom_range(8, 1);
         burst_left = ($urandom_range(3) == 0) ? $urandom_range(80, 40) : $urandom_range(12);
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (expected_grants.size() != 0) @(posedge clock);
   endtask

   // registers change only with nothing in flight
   task automatic set_segment(logic [INDEX_W-1:0] base, logic [CAP_W-1:0] capacity);
      drain();
      repeat (4) @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= REG_SEGMENT_BASE;
      csr_wdata <= base;
      @(posedge clock);
      seg_base   = base;
      csr_index <= REG_SEGMENT_CAPACITY;
      csr_wdata <= {(CSR_DATA_W - CAP_W)'($urandom), capacity};
      @(posedge clock);
      seg_capacity = capacity;
      csr_we      <= 1'b0;
   endtask

   initial begin : request_side
      int                 i;
      int                 p;
      int                 n;
      int                 count;
      int unsigned        roll;
      logic               cmd;
      logic [INDEX_W-1:0] index;
      logic [INDEX_W-1:0] recent_release;
      logic [INDEX_W-1:0] base;
      logic [CAP_W-1:0]   capacity;

      recent_release = '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (i = 0; i < NUM_DIRECTED; i++) begin
         if (DIRECTED[i].kind == STEP_SETUP)
            set_segment(DIRECTED[i].index, DIRECTED[i].capacity);
         else begin
            issue(DIRECTED[i].cmd, DIRECTED[i].index, DIRECTED[i].kind == STEP_KNOWN,
                  DIRECTED[i].want);
            pace();
         end
      end

      for (p = 0; p < NUM_PHASES; p++) begin
         case (p)
            0: begin base = $urandom;                         capacity = 11'd16;   count = 150; end
            1: begin base = {24'hFF_FFFF, 8'($urandom)};      capacity = 11'd300;  count = 130; end
            2: begin base = '0;                               capacity = 11'd1024; count = 150; end
            3: begin base = $urandom;                         capacity = 11'd0;    count = 20;  end
            4: begin base = INVALID_INDEX;                    capacity = 11'd5;    count = 60;  end
            default: begin
               base     = $urandom;
               capacity = CAP_W'($urandom_range(1024, 1));
               count    = 190;
            end
         endcase
         set_segment(base, capacity);
         for (n = 0; n < count; n++) begin
            roll  = $urandom_range(99);
            index = $urandom;
            cmd   = CMD_ALLOCATE;
            if (roll >= 45 && roll < 85 && held_slots.size() != 0) begin
               cmd   = CMD_RELEASE;
               index = seg_base + held_slots[$urandom_range(held_slots.size() - 1)];
            end else if (roll >= 85) begin
               cmd = CMD_RELEASE;
               case ($urandom_range(4))
                  0: ;
                  1: index = INVALID_INDEX;
                  2: index = recent_release;
                  3: index = seg_base + $urandom_range(1100);
                  default: index = seg_base - 1;
               endcase
            end
            if (cmd == CMD_RELEASE)
               recent_release = index;
            issue(cmd, index, 1'b0, NO_RESULT);
            pace();
            // let every outstanding response come back once mid-phase
            if (p == NUM_PHASES - 1 && n == 90)
               drain();
         end
      end

      drain();
      repeat (10) @(posedge clock);
      if (failures == 0)
         $display("descriptor_index_allocator: match");
      else
         $display("descriptor_index_allocator: mismatch");
      $finish;
   end

   initial begin : response_side
      alloc_result_type got;
      alloc_result_type want;
      logic [15:0]      pattern;
      int               step;
      int               hold_left;
      int               seen;

      pattern   = '1;
      step      = 0;
      hold_left = 0;
      seen      = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid && rsp_tready) begin
            got.granted   = rsp_tdata[31:0];
            got.ok        = rsp_tdata[32];
            got.allocated = rsp_tdata[43:33];
            got.available = rsp_tdata[54:44];
            if (expected_grants.size() == 0) begin
               $error("response transfer with no request outstanding");
               failures++;
            end else begin
               want = expected_grants.pop_front();
               check_field("granted_index", want.granted, got.granted);
               check_field("ok", INDEX_W'(want.ok), INDEX_W'(got.ok));
               check_field("allocated_count", INDEX_W'(want.allocated),
                           INDEX_W'(got.allocated));
               check_field("available_count", INDEX_W'(want.available),
                           INDEX_W'(got.available));
            end
            seen++;
            // hold off long enough for the block to back up its input
            if (seen == 250 || seen == 600)
               hold_left = 48;
         end
         if (hold_left != 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            if (step[5:0] == 0)
               pattern = ($urandom_range(2) == 0) ? 16'hFFFF : 16'($urandom);
            rsp_tready <= pattern[step[3:0]];
            step++;
         end
      end
   end

   initial begin : watchdog
      #(LIMIT_CYCLES * CLK_PERIOD);
      $display("descriptor_index_allocator: mismatch");
      $finish;
   end

endmodule
